### hdl/rpw_pkg.sv
package rpw_pkg;

    // Default sizing of the ratio table and the fixed-point fraction
    localparam int DEF_MAX_RATIOS    = 16;
    localparam int DEF_FRACTION_BITS = 16;

    // Field widths fixed by the interface
    localparam int ENTRY_W = 4;
    localparam int RATIO_W = 16;
    localparam int PHASE_W = 17;
    localparam int FRAC_W  = 17;
    localparam int STEPNO_W = 5;
    localparam int PW_W    = 17;
    localparam int RC_W    = 5;

    // Stream payload widths (whole bytes)
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 80;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_COUNT = 2'd1;
    localparam logic [PW_W-1:0] PW_RESET = 17'd32768;
    localparam logic [RC_W-1:0] RC_RESET = 5'd0;

    // Item kinds carried on tuser
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

endpackage

### hdl/ratio_phase_warp_core.sv
// Step-ratio phase warper.
// Slave stream: tuser is the item kind. A load item writes one ratio of the
// table and gives no result. An evaluate item carries a phase and gives
// exactly one result item on the master stream.
// Config channel: index 0 is pulse_width, index 1 is ratio_count; always ready.
// An evaluate runs the ratio wave through a row of MAX_RATIOS cells twice
// (once for the total, once to find the step), one multiply, then four
// quotients on one shared serial divider. A degenerate result (zero count or
// zero total) skips the scan, the multiply and the divider. One evaluate is
// in flight at a time: no item is accepted until its result is handed to the
// output register. The cell row length and the divider set how long an
// evaluate takes.
// The result sits in an output register: the next item is accepted while it
// waits, and a stalled receiver holds only the final hand-over of the next
// evaluate. Reset clears the table to zero, pulse_width to one half and
// ratio_count to zero, and drops any result not yet taken.
module ratio_phase_warp_core #(
    parameter int MAX_RATIOS    = rpw_pkg::DEF_MAX_RATIOS,
    parameter int FRACTION_BITS = rpw_pkg::DEF_FRACTION_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // entry_index[3:0], ratio_value[19:4], phase[36:20]
    input  logic [rpw_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // kind
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // trigger[0], step_start[17:1], step_number[22:18], index_fraction[39:23],
    // beat_phase[56:40], warped_phase[73:57]
    output logic [rpw_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // degenerate
    output logic                             o_m_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rpw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rpw_pkg::PW_W-1:0]         i_cfg_data
);

    localparam int FB      = FRACTION_BITS;
    localparam int QW      = FB + 1;
    localparam int SUM_W   = rpw_pkg::RATIO_W + $clog2(MAX_RATIOS + 1);
    localparam int STEP_W  = (MAX_RATIOS > 1) ? $clog2(MAX_RATIOS) : 1;
    localparam int COUNT_W = $clog2(MAX_RATIOS + 1);
    localparam int TW      = SUM_W + QW;
    localparam int WAVE_W  = 2 * SUM_W + rpw_pkg::RATIO_W + STEP_W + 1;
    localparam int CMP_W   = (COUNT_W > rpw_pkg::RC_W) ? COUNT_W : rpw_pkg::RC_W;
    localparam int PH_W    = (QW > rpw_pkg::PHASE_W) ? QW : rpw_pkg::PHASE_W;
    localparam int TR_W    = (QW > rpw_pkg::PW_W) ? QW : rpw_pkg::PW_W;
    localparam int IW      = (STEP_W > rpw_pkg::ENTRY_W) ? STEP_W : rpw_pkg::ENTRY_W;
    localparam logic [PH_W-1:0] ONE_PH = PH_W'(1) << FB;
    localparam logic [QW-1:0]   ONE_Q  = QW'(1) << FB;

    typedef struct packed {
        logic [SUM_W-1:0]            acc;
        logic [SUM_W-1:0]            last;
        logic [rpw_pkg::RATIO_W-1:0] w;
        logic [STEP_W-1:0]           step;
        logic                        found;
    } t_wave;

    typedef enum logic [2:0] {
        S_IDLE, S_SUM, S_MUL, S_SCAN, S_DLAUNCH, S_DWAIT, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        D_BEAT, D_START, D_INDEX, D_WARP
    } t_dsel;

    t_state                     r_state;
    t_dsel                      r_dsel;
    logic [COUNT_W-1:0]         r_cnt;
    logic                       r_scan;
    logic [QW-1:0]              r_phase;
    logic [SUM_W-1:0]           r_total;
    logic [TW-1:0]              r_target;
    logic [SUM_W-1:0]           r_last;
    logic [rpw_pkg::RATIO_W-1:0] r_w;
    logic [STEP_W-1:0]          r_step;
    logic [QW-1:0]              r_beat;
    logic [QW-1:0]              r_qstart;
    logic [QW-1:0]              r_qindex;
    logic [QW-1:0]              r_qwarp;
    logic                       r_deg;
    logic [rpw_pkg::PW_W-1:0]   r_pw;
    logic [rpw_pkg::RC_W-1:0]   r_rc;
    logic                       r_m_valid;
    logic [rpw_pkg::M_TDATA_W-1:0] r_m_data;
    logic                       r_m_user;

    logic [WAVE_W-1:0]          w_wave [0:MAX_RATIOS];
    t_wave                      w_tail;
    logic [COUNT_W-1:0]         w_count;
    logic                       w_s_acc;
    logic [PH_W-1:0]            w_ph;
    logic [TW-1:0]              w_prod;
    logic [TW-1:0]              w_diff;
    logic                       w_div_start;
    logic                       w_div_busy;
    logic [TW-1:0]              w_dvd;
    logic [SUM_W-1:0]           w_dvs;
    logic [QW-1:0]              w_quo;
    logic [QW-1:0]              w_beat_q;
    logic                       w_trig;
    logic                       w_out_go;

    // Effective entry count, limited to the table size
    assign w_count = (CMP_W'(r_rc) > CMP_W'(MAX_RATIOS)) ? COUNT_W'(MAX_RATIOS)
                                                         : COUNT_W'(r_rc);

    assign o_s_tready  = (r_state == S_IDLE);
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw <= rpw_pkg::PW_RESET;
            r_rc <= rpw_pkg::RC_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rpw_pkg::CFG_PULSE_WIDTH: r_pw <= i_cfg_data;
                rpw_pkg::CFG_RATIO_COUNT: r_rc <= i_cfg_data[rpw_pkg::RC_W-1:0];
                default: ;
            endcase
        end
    end

    // Row of ratio cells
    assign w_wave[0] = '0;
    for (genvar g = 0; g < MAX_RATIOS; g++) begin : g_cell
        logic w_we;
        assign w_we = w_s_acc && (i_s_tuser == rpw_pkg::KIND_LOAD)
                      && (IW'(i_s_tdata[rpw_pkg::ENTRY_W-1:0]) == IW'(g));
        rpw_cell #(
            .CELL_IDX (g),
            .SUM_W    (SUM_W),
            .STEP_W   (STEP_W),
            .COUNT_W  (COUNT_W),
            .FB       (FB),
            .TW       (TW),
            .WAVE_W   (WAVE_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_we     (w_we),
            .i_ratio  (i_s_tdata[19:4]),
            .i_scan   (r_scan),
            .i_count  (w_count),
            .i_target (r_target),
            .i_wave   (w_wave[g]),
            .o_wave   (w_wave[g+1])
        );
    end
    assign w_tail = t_wave'(w_wave[MAX_RATIOS]);

    // Phase field of the slave data; it is saturated to one when captured
    assign w_ph   = PH_W'(i_s_tdata[36:20]);
    assign w_prod = r_total * r_phase;
    assign w_diff = r_target - TW'({r_last, {FB{1'b0}}});

    // Pick the operands of the shared divider
    always_comb begin
        case (r_dsel)
            D_BEAT: begin
                w_dvd = w_diff;
                w_dvs = SUM_W'(r_w);
            end
            D_START: begin
                w_dvd = TW'({r_last, {FB{1'b0}}});
                w_dvs = r_total;
            end
            D_INDEX: begin
                w_dvd = TW'({r_step, {FB{1'b0}}});
                w_dvs = SUM_W'(w_count);
            end
            default: begin
                w_dvd = TW'({r_step, {FB{1'b0}}}) + TW'(r_beat);
                w_dvs = SUM_W'(w_count);
            end
        endcase
    end

    assign w_div_start = (r_state == S_DLAUNCH);

    rpw_div #(
        .DW (SUM_W),
        .QW (QW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // Zero-width step gives zero; clamp to one
    assign w_beat_q = (r_w == '0) ? '0 : ((w_quo > ONE_Q) ? ONE_Q : w_quo);
    assign w_trig   = TR_W'(r_beat) <= TR_W'(r_pw);

    // Hand over once the previous result is gone
    assign w_out_go = (r_state == S_OUT) && (!r_m_valid || i_m_tready);

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dsel    <= D_BEAT;
            r_cnt     <= '0;
            r_scan    <= 1'b0;
            r_m_valid <= 1'b0;
            r_deg     <= 1'b0;
        end else begin
            if (w_out_go) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_s_acc && (i_s_tuser == rpw_pkg::KIND_EVAL)) begin
                        r_phase <= (w_ph > ONE_PH) ? ONE_Q : QW'(w_ph);
                        r_scan  <= 1'b0;
                        r_cnt   <= '0;
                        r_deg   <= 1'b0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_cnt == COUNT_W'(MAX_RATIOS)) begin
                        r_total <= w_tail.acc;
                        if (w_count == '0 || w_tail.acc == '0) begin
                            r_deg   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MUL: begin
                    r_target <= w_prod;
                    r_scan   <= 1'b1;
                    r_cnt    <= '0;
                    r_state  <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_cnt == COUNT_W'(MAX_RATIOS)) begin
                        r_last  <= w_tail.last;
                        r_w     <= w_tail.w;
                        r_step  <= w_tail.step;
                        r_dsel  <= D_BEAT;
                        r_state <= S_DLAUNCH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DLAUNCH: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (!w_div_busy) begin
                        case (r_dsel)
                            D_BEAT:  r_beat   <= w_beat_q;
                            D_START: r_qstart <= w_quo;
                            D_INDEX: r_qindex <= w_quo;
                            default: r_qwarp  <= w_quo;
                        endcase
                        if (r_dsel == D_WARP) begin
                            r_state <= S_OUT;
                        end else begin
                            r_dsel  <= t_dsel'(r_dsel + 2'd1);
                            r_state <= S_DLAUNCH;
                        end
                    end
                end
                S_OUT: begin
                    // Load the output register; a degenerate result is all zero
                    if (w_out_go) begin
                        r_m_data  <= r_deg ? '0 : rpw_pkg::M_TDATA_W'({
                                         rpw_pkg::FRAC_W'(r_qwarp),
                                         rpw_pkg::FRAC_W'(r_beat),
                                         rpw_pkg::FRAC_W'(r_qindex),
                                         rpw_pkg::STEPNO_W'(r_step),
                                         rpw_pkg::FRAC_W'(r_qstart),
                                         w_trig});
                        r_m_user  <= r_deg;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // A degenerate result carries all-zero data
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("degenerate result with non-zero data");

    // Trigger agrees with beat phase and pulse width
    a_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser && (r_state == S_IDLE))
        |-> (o_m_tdata[0] == (o_m_tdata[56:40] <= r_pw)))
        else $error("trigger does not match beat phase");

    // Divider is never restarted mid-run
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider restarted while busy");

    // Scan only ever runs on a non-zero total
    a_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_total != '0))
        else $error("scan started with zero total");

endmodule

### hdl/rpw_cell.sv
module rpw_cell #(
    parameter int CELL_IDX = 0,
    parameter int SUM_W    = 20,
    parameter int STEP_W   = 4,
    parameter int COUNT_W  = 5,
    parameter int FB       = 16,
    parameter int TW       = 37,
    parameter int WAVE_W   = 2 * 20 + 16 + 4 + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [rpw_pkg::RATIO_W-1:0] i_ratio,
    input  logic                       i_scan,
    input  logic [COUNT_W-1:0]         i_count,
    input  logic [TW-1:0]              i_target,
    input  logic [WAVE_W-1:0]          i_wave,
    output logic [WAVE_W-1:0]          o_wave
);

    typedef struct packed {
        logic [SUM_W-1:0]            acc;
        logic [SUM_W-1:0]            last;
        logic [rpw_pkg::RATIO_W-1:0] w;
        logic [STEP_W-1:0]           step;
        logic                        found;
    } t_wave;

    logic [rpw_pkg::RATIO_W-1:0] r_entry;
    t_wave                       w_in;
    t_wave                       n_out;
    t_wave                       r_out;
    logic                        w_active;
    logic [SUM_W-1:0]            w_acc;
    logic [TW-1:0]               w_acc_scaled;
    logic                        w_hit;

    // Hold this cell's table entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_we) begin
            r_entry <= i_ratio;
        end
    end

    assign w_in         = t_wave'(i_wave);
    assign w_active     = COUNT_W'(CELL_IDX) < i_count;
    assign w_acc        = w_in.acc + SUM_W'(r_entry);
    assign w_acc_scaled = TW'({w_acc, {FB{1'b0}}});
    assign w_hit        = i_target <= w_acc_scaled;

    // Add this entry to the running sum; in scan mode mark the first step reached
    always_comb begin
        n_out = w_in;
        if (w_active) begin
            if (!i_scan) begin
                n_out.acc = w_acc;
            end else if (!w_in.found) begin
                n_out.acc = w_acc;
                if (w_hit) begin
                    n_out.found = 1'b1;
                    n_out.step  = STEP_W'(CELL_IDX);
                    n_out.w     = r_entry;
                    n_out.last  = w_in.acc;
                end else begin
                    n_out.last  = w_acc;
                end
            end
        end
    end

    // Hand the wave to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else begin
            r_out <= n_out;
        end
    end

    assign o_wave = WAVE_W'(r_out);

endmodule

### hdl/rpw_div.sv
module rpw_div #(
    parameter int DW = 20,
    parameter int QW = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW+QW-1:0] i_dividend,
    input  logic [DW-1:0]    i_divisor,
    output logic             o_busy,
    output logic [QW-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(QW + 1);

    logic [DW-1:0]    r_rem;
    logic [QW-1:0]    r_q;
    logic [DW-1:0]    r_d;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DW:0]      w_rem2;
    logic             w_ge;
    logic [DW:0]      w_diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign w_rem2 = {r_rem, r_q[QW-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_d};
    assign w_diff = w_rem2 - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(QW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DW+QW-1:QW];
            r_q   <= i_dividend[QW-1:0];
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_rem2[DW-1:0];
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_q;

endmodule
